>>> rtl/ptt_pkg.sv
// Shared types and constants for the periodic timer table.
// Used by the top level and ptt_ticks; depends on nothing else.
`default_nettype none

package ptt_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int SLOT_W     = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

  localparam int ID_W      = 28;
  localparam int TICKS_W   = 29;
  localparam int REPEAT_W  = 32;
  localparam int TARGET_W  = 29;
  localparam int MS_W      = 32;
  localparam int FUNC_W    = 3;
  localparam int STATUS_W  = 2;

  localparam logic [ID_W-1:0] FIRST_ID_BASE = 28'h000_0010;
  localparam logic [ID_W-1:0] ID_WRAP_POINT = 28'hF00_0000;

  // timeout_ms / TICK_MS by multiplication with a rounded-up reciprocal
  localparam int TICK_MS   = 10;
  localparam int DIV_SHIFT = 35;
  localparam logic [MS_W-1:0] DIV_MAGIC =
    32'(((64'd1 << DIV_SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

  localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_START  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHANGE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_STOP   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [TICKS_W-1:0]  remain;
    logic [TICKS_W-1:0]  reload;
    logic [REPEAT_W-1:0] repeats;
    logic                forever_flag;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     result_id;
    logic                exists;
    logic                fired;
    logic                last;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/periodic_timer_table.sv
// Periodic timer table: top level with the slot walker and result register.
// Depends on ptt_pkg, ptt_slot_ram and ptt_ticks.
//
// Usage: each input transfer on s_axis carries one operation in tuser (tick,
// start, change, stop, query). Every operation gives exactly one result on
// m_axis, except a tick, which gives one result per expiring timer in slot
// order (tuser set), or a single result with tuser clear if none expires.
// tlast marks the final result of each operation.
// Start and unused codes do not read the slot memory; tick, change, stop and
// query walk it one slot a cycle, set by its single read port, unless a tick
// walk stalls; change, stop and query end at the first matching slot.
// The next input is taken only once the result is in the output register.
// After a walk, the final result goes to resp and then the output register.
// A stalled receiver holds the result register; a tick walk pauses at the
// next expiring timer until the register frees, other operations finish
// their walk and wait before the next input is taken.
// Reset clears all slots, sets the id counter to 0x10 and forever_marker
// to all ones; the slot memory needs no clearing pass.
`default_nettype none

module periodic_timer_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // target_id [28:0], timeout [60:29], repeats [92:61], zero [95:93]
  input  wire logic [95:0] s_axis_tdata,
  // func [2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status [1:0], result_id [29:2], exists [30], zero [31]
  output logic [31:0]      m_axis_tdata,
  // fired [0]
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CALC, ST_START, ST_READ, ST_PROC, ST_RESP
  } state_t;

  state_t state;

  logic [ptt_pkg::FUNC_W-1:0]     func_q;
  logic [ptt_pkg::TARGET_W-1:0]   target_q;
  logic [ptt_pkg::MS_W-1:0]       tmo_q;
  logic [ptt_pkg::REPEAT_W-1:0]   rep_q;
  logic [31:0]                    forever_marker;
  logic [ptt_pkg::MAX_TIMERS-1:0] slot_valid;
  logic [ptt_pkg::ID_W-1:0]       last_given_id;
  logic [ptt_pkg::SLOT_W-1:0]     idx;
  logic                           pend_valid;
  logic [ptt_pkg::ID_W-1:0]       pend_id;
  ptt_pkg::result_t               resp;
  logic                           out_valid;
  ptt_pkg::result_t               out_data;

  logic [ptt_pkg::TICKS_W-1:0]    ticks;
  logic [ptt_pkg::ENTRY_W-1:0]    rdata;
  ptt_pkg::slot_entry_t           e;
  ptt_pkg::slot_entry_t           wentry;
  logic                           mem_we;
  logic [ptt_pkg::SLOT_W-1:0]     mem_waddr;
  logic                           mem_re;
  logic [ptt_pkg::SLOT_W-1:0]     mem_raddr;

  logic                           out_free;
  logic                           out_load;
  logic                           v;
  logic [ptt_pkg::TICKS_W-1:0]    rem_dec;
  logic [ptt_pkg::REPEAT_W-1:0]   rep_dec;
  logic                           fire;
  logic                           keep;
  logic                           match;
  logic                           is_tick;
  logic                           last_slot;
  logic                           proc_stall;
  logic                           proc_go;
  logic                           free_found;
  logic [ptt_pkg::SLOT_W-1:0]     free_idx;
  logic [ptt_pkg::ID_W-1:0]       new_id;
  logic                           fin_pend;
  logic [ptt_pkg::ID_W-1:0]       fin_id;

  ptt_ticks u_ticks (
    .clk      (clk),
    .delay_ms (tmo_q),
    .ticks    (ticks)
  );

  ptt_slot_ram #(
    .DATA_W (ptt_pkg::ENTRY_W),
    .DEPTH  (ptt_pkg::MAX_TIMERS),
    .ADDR_W (ptt_pkg::SLOT_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wentry),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  assign e             = ptt_pkg::slot_entry_t'(rdata);
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !out_valid || m_axis_tready;

  assign v          = slot_valid[idx];
  assign rem_dec    = (e.remain != '0) ? e.remain - ptt_pkg::TICKS_W'(1) : '0;
  assign fire       = v && (rem_dec == '0);
  assign rep_dec    = (!e.forever_flag && e.repeats != '0) ?
                      e.repeats - ptt_pkg::REPEAT_W'(1) : e.repeats;
  assign keep       = e.forever_flag || (rep_dec != '0);
  assign match      = v && !target_q[ptt_pkg::TARGET_W-1] &&
                      (e.id == target_q[ptt_pkg::ID_W-1:0]);
  assign is_tick    = (func_q == ptt_pkg::FUNC_TICK);
  assign last_slot  = (idx == ptt_pkg::SLOT_W'(ptt_pkg::MAX_TIMERS - 1));
  assign proc_stall = is_tick && fire && pend_valid && !out_free;
  assign proc_go    = (state == ST_PROC) && !proc_stall;
  assign new_id     = last_given_id + ptt_pkg::ID_W'(1);
  assign fin_pend   = pend_valid || fire;
  assign fin_id     = fire ? e.id : pend_id;
  assign out_load   = (proc_go && is_tick && fire && pend_valid) ||
                      ((state == ST_RESP) && out_free);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ptt_pkg::MAX_TIMERS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = ptt_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    mem_re    = (state == ST_READ) ||
                (proc_go && !last_slot && (is_tick || !match));
    mem_raddr = (state == ST_READ) ? idx : idx + ptt_pkg::SLOT_W'(1);
    mem_we    = 1'b0;
    mem_waddr = idx;
    wentry    = e;
    if (state == ST_START) begin
      mem_we               = free_found;
      mem_waddr            = free_idx;
      wentry.id            = new_id;
      wentry.remain        = ticks;
      wentry.reload        = ticks;
      wentry.repeats       = rep_q;
      wentry.forever_flag  = (rep_q == forever_marker);
    end else if (proc_go && is_tick) begin
      mem_we = v;
      if (fire) begin
        wentry.remain  = keep ? e.reload : rem_dec;
        wentry.repeats = rep_dec;
      end else begin
        wentry.remain  = rem_dec;
      end
    end else if (proc_go && func_q == ptt_pkg::FUNC_CHANGE) begin
      mem_we         = match;
      wentry.remain  = ticks;
      wentry.reload  = ticks;
      wentry.repeats = rep_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      forever_marker <= '1;
      slot_valid     <= '0;
      last_given_id  <= ptt_pkg::FIRST_ID_BASE;
      pend_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        forever_marker <= cfg_wdata;
      end
      out_valid <= out_load || (out_valid && !m_axis_tready);
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            func_q   <= s_axis_tuser;
            target_q <= s_axis_tdata[28:0];
            tmo_q    <= s_axis_tdata[60:29];
            rep_q    <= s_axis_tdata[92:61];
            state    <= ST_CALC;
          end
        end
        ST_CALC: begin
          idx        <= '0;
          pend_valid <= 1'b0;
          case (func_q) inside
            ptt_pkg::FUNC_START: begin
              state <= ST_START;
            end
            ptt_pkg::FUNC_TICK, ptt_pkg::FUNC_CHANGE,
            ptt_pkg::FUNC_STOP, ptt_pkg::FUNC_QUERY: begin
              state <= ST_READ;
            end
            default: begin
              resp  <= '{status: ptt_pkg::STATUS_OK, result_id: '0, exists: 1'b0,
                         fired: 1'b0, last: 1'b1};
              state <= ST_RESP;
            end
          endcase
        end
        ST_START: begin
          if (free_found) begin
            slot_valid[free_idx] <= 1'b1;
            last_given_id <= (new_id == ptt_pkg::ID_WRAP_POINT) ?
                             ptt_pkg::FIRST_ID_BASE : new_id;
            resp <= '{status: ptt_pkg::STATUS_OK, result_id: new_id, exists: 1'b0,
                      fired: 1'b0, last: 1'b1};
          end else begin
            resp <= '{status: ptt_pkg::STATUS_FULL, result_id: '0, exists: 1'b0,
                      fired: 1'b0, last: 1'b1};
          end
          state <= ST_RESP;
        end
        ST_READ: begin
          state <= ST_PROC;
        end
        ST_PROC: begin
          if (!proc_stall) begin
            if (is_tick) begin
              if (fire) begin
                if (!keep) begin
                  slot_valid[idx] <= 1'b0;
                end
                if (pend_valid) begin
                  out_data  <= '{status: ptt_pkg::STATUS_OK, result_id: pend_id,
                                 exists: 1'b0, fired: 1'b1, last: 1'b0};
                end
                pend_valid <= 1'b1;
                pend_id    <= e.id;
              end
              if (last_slot) begin
                resp  <= '{status: ptt_pkg::STATUS_OK,
                           result_id: fin_pend ? fin_id : '0,
                           exists: 1'b0, fired: fin_pend, last: 1'b1};
                state <= ST_RESP;
              end else begin
                idx <= idx + ptt_pkg::SLOT_W'(1);
              end
            end else if (match) begin
              if (func_q == ptt_pkg::FUNC_STOP) begin
                slot_valid[idx] <= 1'b0;
              end
              resp  <= '{status: ptt_pkg::STATUS_OK, result_id: '0,
                         exists: (func_q == ptt_pkg::FUNC_QUERY),
                         fired: 1'b0, last: 1'b1};
              state <= ST_RESP;
            end else if (last_slot) begin
              resp  <= '{status: (func_q == ptt_pkg::FUNC_CHANGE) ?
                                 ptt_pkg::STATUS_NOT_FOUND : ptt_pkg::STATUS_OK,
                         result_id: '0, exists: 1'b0, fired: 1'b0, last: 1'b1};
              state <= ST_RESP;
            end else begin
              idx <= idx + ptt_pkg::SLOT_W'(1);
            end
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_data   <= resp;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_data.exists, out_data.result_id, out_data.status};
  assign m_axis_tuser  = out_data.fired;
  assign m_axis_tlast  = out_data.last;

  a_id_never_wrap: assert property (@(posedge clk) disable iff (rst)
    last_given_id != ptt_pkg::ID_WRAP_POINT)
    else $error("id counter holds the wrap point");

  a_start_claims_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_START) && free_found |=>
      $countones(slot_valid) == $countones($past(slot_valid)) + 1)
    else $error("start did not claim exactly one slot");

  a_pend_in_walk: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == ST_PROC) || (state == ST_RESP))
    else $error("pending firing outside a tick walk");

  a_proc_write_own_slot: assert property (@(posedge clk) disable iff (rst)
    mem_we && (state == ST_PROC) |-> mem_waddr == idx && !(mem_re && mem_raddr == idx))
    else $error("walk write overlaps its own read");

endmodule

`default_nettype wire

>>> rtl/ptt_slot_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the timer slot entries; no package dependency.
`default_nettype none

module ptt_slot_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ptt_ticks.sv
// Converts a millisecond timeout into a tick count, at least one tick.
// One registered reciprocal multiply; uses ptt_pkg constants.
`default_nettype none

module ptt_ticks (
  input  wire logic                         clk,
  input  wire logic [ptt_pkg::MS_W-1:0]     delay_ms,
  output logic      [ptt_pkg::TICKS_W-1:0]  ticks
);

  logic [2*ptt_pkg::MS_W-1:0] prod;
  logic [ptt_pkg::TICKS_W-1:0] quot;

  always_ff @(posedge clk) begin
    prod <= 64'(delay_ms) * 64'(ptt_pkg::DIV_MAGIC);
  end

  assign quot  = prod[ptt_pkg::DIV_SHIFT +: ptt_pkg::TICKS_W];
  assign ticks = (quot == '0) ? ptt_pkg::TICKS_W'(1) : quot;

endmodule

`default_nettype wire
